// ===== rtl/bdee_pkg.sv =====
// ----------------------------------------------------------------------------
// bdee_pkg
// Types, codes and constants shared by the button debounce event engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bdee_pkg;

  localparam int NUM_BUTTONS = 16;
  localparam int SLOT_W      = $clog2(NUM_BUTTONS);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int OUT_DEPTH   = 4;
  localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W   = OUT_PTR_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EVENT_ENABLE  = 2'd3;

  localparam logic [15:0] DEBOUNCE_MS_RST   = 16'd20;
  localparam logic [15:0] LONG_PRESS_MS_RST = 16'd1000;
  localparam logic [15:0] ACTIVE_LOW_RST    = 16'h0000;
  localparam logic [15:0] EVENT_ENABLE_RST  = 16'hFFFF;

  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_ATTACH = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  localparam logic [1:0] EV_PRESSED  = 2'd0;
  localparam logic [1:0] EV_RELEASED = 2'd1;
  localparam logic [1:0] EV_CLICKED  = 2'd2;
  localparam logic [1:0] EV_LONG     = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  button_index;
    logic        raw_level;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [3:0] event_slot;
    logic [1:0] event_code;
    logic       last_in_run;
  } out_item_t;

  typedef struct packed {
    logic        last_raw;
    logic        debounced;
    logic        long_flag;
    logic [31:0] change_time;
  } slot_entry_t;

endpackage

`default_nettype wire

// ===== rtl/button_debounce_event_engine.sv =====
// ----------------------------------------------------------------------------
// button_debounce_event_engine
// Debounces up to sixteen button slots and reports press, release, click and
// long-press events.
// ----------------------------------------------------------------------------
// Usage: each input transaction on in_* attaches, removes or samples one slot.
// Slot state lives in a synchronous table with one read and one write port. It
// is read at accept time and written back from the stage register, with the
// write data forwarded when the next transaction reads the same slot. A
// transaction is taken every cycle while in_stall is low; the table
// read-modify-write sets that rate. Each sample yields zero, one or two event
// transactions on out_*, pushed from the stage register into a four-entry
// result queue. The output side moves one result per cycle while out_stall is
// low, so runs of two-event samples are limited by it. When the receiver
// stalls, the queue fills; intake stops while a transaction waits to be queued
// and fewer than two queue entries are free. Reset clears all attach bits,
// empties the queue and loads the default thresholds and masks. The user
// writes registers on the cfg_* port only while the block idles; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_event_engine (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  bdee_pkg::in_item_t           in_item,
  output logic                               out_valid,
  input  wire                                out_stall,
  output bdee_pkg::out_item_t                out_item,
  input  wire                                cfg_we,
  input  wire  [bdee_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [bdee_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [15:0] debounce_ms_r;
  logic [15:0] long_press_ms_r;
  logic [15:0] active_low_r;
  logic [15:0] event_enable_r;

  logic [bdee_pkg::NUM_BUTTONS-1:0] slot_valid_r;
  logic [bdee_pkg::NUM_BUTTONS-1:0] slot_valid_nxt;
  bdee_pkg::slot_entry_t            slot_mem_r [bdee_pkg::NUM_BUTTONS];
  bdee_pkg::slot_entry_t            rdata_r;

  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  bdee_pkg::in_item_t   s1_item_r;

  bdee_pkg::out_item_t              fifo_r [bdee_pkg::OUT_DEPTH];
  logic [bdee_pkg::OUT_PTR_W-1:0]   wptr_r;
  logic [bdee_pkg::OUT_PTR_W-1:0]   wptr_nxt;
  logic [bdee_pkg::OUT_PTR_W-1:0]   rptr_r;
  logic [bdee_pkg::OUT_PTR_W-1:0]   rptr_nxt;
  logic [bdee_pkg::OUT_CNT_W-1:0]   count_r;
  logic [bdee_pkg::OUT_CNT_W-1:0]   count_nxt;

  logic                          in_accept;
  logic                          s1_go;
  logic                          pop;
  logic [bdee_pkg::SLOT_W-1:0]   rd_slot;
  logic [bdee_pkg::SLOT_W-1:0]   s1_slot;
  logic                          in_range;
  logic                          pol;
  logic                          en;
  logic                          is_sample;
  logic                          mem_we;
  bdee_pkg::slot_entry_t         wdata;
  bdee_pkg::slot_entry_t         upd;
  logic [31:0]                   elapsed;
  logic [31:0]                   elapsed_long;
  logic                          changed;
  logic                          accept_lvl;
  logic                          fire_long;
  logic [1:0]                    db_n;
  logic [1:0]                    db_c0;
  logic [1:0]                    db_c1;
  logic [1:0]                    push_n;
  bdee_pkg::out_item_t           ev0;
  bdee_pkg::out_item_t           ev1;

  assign s1_go     = !s1_valid_r || (count_r <= bdee_pkg::OUT_CNT_W'(bdee_pkg::OUT_DEPTH - 2));
  assign in_stall  = !s1_go;
  assign in_accept = in_valid && s1_go;
  assign pop       = out_valid && !out_stall;
  assign out_valid = (count_r != '0);
  assign out_item  = fifo_r[rptr_r];

  assign rd_slot = in_item.button_index[bdee_pkg::SLOT_W-1:0];
  assign s1_slot = s1_item_r.button_index[bdee_pkg::SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r   <= bdee_pkg::DEBOUNCE_MS_RST;
      long_press_ms_r <= bdee_pkg::LONG_PRESS_MS_RST;
      active_low_r    <= bdee_pkg::ACTIVE_LOW_RST;
      event_enable_r  <= bdee_pkg::EVENT_ENABLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bdee_pkg::REG_DEBOUNCE_MS:   debounce_ms_r   <= cfg_wdata;
        bdee_pkg::REG_LONG_PRESS_MS: long_press_ms_r <= cfg_wdata;
        bdee_pkg::REG_ACTIVE_LOW:    active_low_r    <= cfg_wdata;
        bdee_pkg::REG_EVENT_ENABLE:  event_enable_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_range  = (32'(s1_item_r.button_index) < 32'(bdee_pkg::NUM_BUTTONS));
    pol       = s1_item_r.raw_level ^ active_low_r[s1_item_r.button_index];
    en        = event_enable_r[s1_item_r.button_index];
    is_sample = (s1_item_r.req_type == bdee_pkg::REQ_SAMPLE) && slot_valid_r[s1_slot];

    elapsed      = s1_item_r.now_ms - rdata_r.change_time;
    changed      = (pol != rdata_r.last_raw);
    accept_lvl   = !changed && (pol != rdata_r.debounced) &&
                   (elapsed >= 32'(debounce_ms_r));
    elapsed_long = changed ? 32'd0 : elapsed;

    upd   = rdata_r;
    db_n  = 2'd0;
    db_c0 = bdee_pkg::EV_PRESSED;
    db_c1 = bdee_pkg::EV_CLICKED;
    if (changed) begin
      upd.change_time = s1_item_r.now_ms;
      upd.last_raw    = pol;
    end else if (accept_lvl) begin
      upd.debounced = pol;
      if (pol) begin
        db_n  = 2'd1;
        db_c0 = bdee_pkg::EV_PRESSED;
      end else begin
        db_c0 = bdee_pkg::EV_RELEASED;
        if (rdata_r.long_flag) begin
          upd.long_flag = 1'b0;
          db_n          = 2'd1;
        end else begin
          db_n = 2'd2;
        end
      end
    end
    fire_long = upd.debounced && !upd.long_flag &&
                (elapsed_long >= 32'(long_press_ms_r));
    if (fire_long) begin
      upd.long_flag = 1'b1;
    end

    ev0.event_slot  = s1_item_r.button_index;
    ev1.event_slot  = s1_item_r.button_index;
    ev0.event_code  = (db_n == 2'd0) ? bdee_pkg::EV_LONG : db_c0;
    ev1.event_code  = (db_n == 2'd2) ? db_c1 : bdee_pkg::EV_LONG;
    push_n          = db_n + {1'b0, fire_long};
    ev0.last_in_run = (push_n == 2'd1);
    ev1.last_in_run = 1'b1;
    if (!(s1_valid_r && s1_go && in_range && is_sample && en)) begin
      push_n = 2'd0;
    end

    wdata          = upd;
    mem_we         = 1'b0;
    slot_valid_nxt = slot_valid_r;
    if (s1_valid_r && s1_go && in_range) begin
      case (s1_item_r.req_type)
        bdee_pkg::REQ_ATTACH: begin
          wdata.last_raw           = pol;
          wdata.debounced          = pol;
          wdata.long_flag          = 1'b0;
          wdata.change_time        = s1_item_r.now_ms;
          mem_we                   = 1'b1;
          slot_valid_nxt[s1_slot]  = 1'b1;
        end
        bdee_pkg::REQ_REMOVE: begin
          slot_valid_nxt[s1_slot] = 1'b0;
        end
        bdee_pkg::REQ_SAMPLE: begin
          mem_we = is_sample;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem_r[s1_slot] <= wdata;
    end
    if (in_accept) begin
      if (mem_we && (s1_slot == rd_slot)) begin
        rdata_r <= wdata;
      end else begin
        rdata_r <= slot_mem_r[rd_slot];
      end
      s1_item_r <= in_item;
    end
  end

  assign s1_valid_nxt = s1_go ? in_valid : s1_valid_r;

  always_comb begin
    wptr_nxt  = wptr_r + bdee_pkg::OUT_PTR_W'(push_n);
    rptr_nxt  = rptr_r + bdee_pkg::OUT_PTR_W'(pop);
    count_nxt = count_r + bdee_pkg::OUT_CNT_W'(push_n) - bdee_pkg::OUT_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_r[wptr_r] <= ev0;
    end
    if (push_n == 2'd2) begin
      fifo_r[wptr_r + bdee_pkg::OUT_PTR_W'(1)] <= ev1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      s1_valid_r   <= 1'b0;
      wptr_r       <= '0;
      rptr_r       <= '0;
      count_r      <= '0;
    end else begin
      slot_valid_r <= slot_valid_nxt;
      s1_valid_r   <= s1_valid_nxt;
      wptr_r       <= wptr_nxt;
      rptr_r       <= rptr_nxt;
      count_r      <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sim/button_debounce_event_engine_tb.sv =====
// ----------------------------------------------------------------------------
// button_debounce_event_engine_tb
// Self-checking testbench for the button debounce event engine. Directed
// press, release, click, long-press, polarity, enable and time-wrap cases
// come first, then randomized scan traffic under several threshold settings.
// An in-bench predictor tracks every slot and queues the events that each
// accepted transaction should cause; a checker compares each event that
// leaves the block with the oldest queued one, field by field.
// ----------------------------------------------------------------------------
module button_debounce_event_engine_tb;

  localparam logic [1:0] REQ_UNUSED     = 2'd3;
  localparam int         DRAIN_CYCLES   = 8;
  localparam int         WATCHDOG_LIMIT = 4000;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  bdee_pkg::in_item_t              in_item = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  bdee_pkg::out_item_t             out_item;
  logic                            cfg_we = 1'b0;
  logic [bdee_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bdee_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  logic [15:0] thr_debounce   = bdee_pkg::DEBOUNCE_MS_RST;
  logic [15:0] thr_long_press = bdee_pkg::LONG_PRESS_MS_RST;
  logic [15:0] pol_low_mask   = bdee_pkg::ACTIVE_LOW_RST;
  logic [15:0] ev_enable_mask = bdee_pkg::EVENT_ENABLE_RST;

  logic        attached [bdee_pkg::NUM_BUTTONS];
  logic        pin_seen [bdee_pkg::NUM_BUTTONS];
  logic        level_ok [bdee_pkg::NUM_BUTTONS];
  logic        long_seen [bdee_pkg::NUM_BUTTONS];
  logic [31:0] edge_stamp [bdee_pkg::NUM_BUTTONS];

  bdee_pkg::out_item_t pending_events [$];
  bdee_pkg::out_item_t want_ev;
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          no_idle = 1'b0;
  logic [31:0] stamp = '0;

  button_debounce_event_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit take_gap();
    return !no_idle && ($urandom_range(0, 99) < 33);
  endfunction

  always @(negedge clk) begin
    out_stall <= take_gap();
  end

  function automatic bdee_pkg::in_item_t mk_item(input logic [1:0] req,
                                                 input int unsigned slot,
                                                 input logic lvl, input logic [31:0] t);
    bdee_pkg::in_item_t it;
    it.req_type     = req;
    it.button_index = slot[3:0];
    it.raw_level    = lvl;
    it.now_ms       = t;
    return it;
  endfunction

  function automatic void predict_events(input bdee_pkg::in_item_t it);
    bdee_pkg::out_item_t evs [$];
    bdee_pkg::out_item_t ev;
    int unsigned slot;
    logic        lvl;
    logic        en;
    logic [31:0] held;
    slot = 32'(it.button_index);
    lvl  = it.raw_level ^ pol_low_mask[slot];
    en   = ev_enable_mask[slot];
    ev.event_slot  = it.button_index;
    ev.last_in_run = 1'b0;
    case (it.req_type)
      bdee_pkg::REQ_ATTACH: begin
        attached[slot]   = 1'b1;
        pin_seen[slot]   = lvl;
        level_ok[slot]   = lvl;
        long_seen[slot]  = 1'b0;
        edge_stamp[slot] = it.now_ms;
      end
      bdee_pkg::REQ_REMOVE: begin
        attached[slot] = 1'b0;
      end
      bdee_pkg::REQ_SAMPLE: begin
        if (attached[slot]) begin
          held = it.now_ms - edge_stamp[slot];
          if (lvl != pin_seen[slot]) begin
            edge_stamp[slot] = it.now_ms;
            pin_seen[slot]   = lvl;
          end else if (lvl != level_ok[slot] && held >= {16'd0, thr_debounce}) begin
            level_ok[slot] = lvl;
            if (lvl) begin
              ev.event_code = bdee_pkg::EV_PRESSED;
              if (en) evs.push_back(ev);
            end else begin
              ev.event_code = bdee_pkg::EV_RELEASED;
              if (en) evs.push_back(ev);
              if (long_seen[slot]) begin
                long_seen[slot] = 1'b0;
              end else begin
                ev.event_code = bdee_pkg::EV_CLICKED;
                if (en) evs.push_back(ev);
              end
            end
          end
          held = it.now_ms - edge_stamp[slot];
          if (level_ok[slot] && !long_seen[slot] && held >= {16'd0, thr_long_press}) begin
            long_seen[slot] = 1'b1;
            ev.event_code   = bdee_pkg::EV_LONG;
            if (en) evs.push_back(ev);
          end
        end
      end
      default: begin
      end
    endcase
    if (evs.size() > 0) evs[evs.size()-1].last_in_run = 1'b1;
    foreach (evs[i]) pending_events.push_back(evs[i]);
  endfunction

  task automatic send_item(input bdee_pkg::in_item_t it);
    @(negedge clk);
    while (take_gap()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_events(it);
  endtask

  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bdee_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      bdee_pkg::REG_DEBOUNCE_MS:   thr_debounce   = val;
      bdee_pkg::REG_LONG_PRESS_MS: thr_long_press = val;
      bdee_pkg::REG_ACTIVE_LOW:    pol_low_mask   = val;
      default:                     ev_enable_mask = val;
    endcase
  endtask

  task automatic apply_settings(input logic [15:0] deb, input logic [15:0] lp,
                                input logic [15:0] low, input logic [15:0] en);
    drain_pipeline();
    write_reg(bdee_pkg::REG_DEBOUNCE_MS, deb);
    write_reg(bdee_pkg::REG_LONG_PRESS_MS, lp);
    write_reg(bdee_pkg::REG_ACTIVE_LOW, low);
    write_reg(bdee_pkg::REG_EVENT_ENABLE, en);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_press_release_click();
    send_item(mk_item(bdee_pkg::REQ_ATTACH, 3, 1'b0, 32'd1000));
    send_item(mk_item(bdee_pkg::REQ_SAMPLE, 3, 1'b1, 32'd1005));
    send_item(mk_item(bdee_pkg::REQ_SAMPLE, 3, 1'b1, 32'd1024));
    send_item(mk_item(bdee_pkg::REQ_SAMPLE, 3, 1'b1, 32'd1025));
    send_item(mk_item(bdee_pkg::REQ_SAMPLE, 3, 1'b0, 32'd1100));
    send_item(mk_item(bdee_pkg::REQ_SAMPLE, 3, 1'b0, 32'd1120));
  endtask

  task automatic test_long_press();
    send_item(mk_item(bdee_pkg::REQ_SAMPLE, 3, 1'b1, 32'd2000));
    send_item(mk_item(bdee_pkg::REQ_SAMPLE, 3, 1'b1, 32'd2020));
    send_item(mk_item(bdee_pkg::REQ_SAMPLE, 3, 1'b1, 32'd2999));
    send_item(mk_item(bdee_pkg::REQ_SAMPLE, 3, 1'b1, 32'd3000));
    send_item(mk_item(bdee_pkg::REQ_SAMPLE, 3, 1'b0, 32'd4001));
    send_item(mk_item(bdee_pkg::REQ_SAMPLE, 3, 1'b0, 32'd4021));
  endtask

  task automatic test_ignored_requests();
    send_item(mk_item(bdee_pkg::REQ_SAMPLE, 9, 1'b1, 32'hFFFF_FFFF));
    send_item(mk_item(REQ_UNUSED, 3, 1'b1, 32'd5000));
    send_item(mk_item(bdee_pkg::REQ_REMOVE, 3, 1'b0, 32'd5000));
    send_item(mk_item(bdee_pkg::REQ_SAMPLE, 3, 1'b1, 32'd9000));
  endtask

  task automatic test_zero_thresholds_polarity_enable();
    apply_settings(16'd0, 16'd0, 16'hFFFF, 16'h7FFF);
    send_item(mk_item(bdee_pkg::REQ_ATTACH, 14, 1'b1, 32'd500));
    send_item(mk_item(bdee_pkg::REQ_SAMPLE, 14, 1'b0, 32'd500));
    send_item(mk_item(bdee_pkg::REQ_SAMPLE, 14, 1'b0, 32'd500));
    send_item(mk_item(bdee_pkg::REQ_ATTACH, 15, 1'b1, 32'd500));
    send_item(mk_item(bdee_pkg::REQ_SAMPLE, 15, 1'b0, 32'd500));
    send_item(mk_item(bdee_pkg::REQ_SAMPLE, 15, 1'b0, 32'd500));
    send_item(mk_item(bdee_pkg::REQ_SAMPLE, 14, 1'b1, 32'd501));
    send_item(mk_item(bdee_pkg::REQ_SAMPLE, 14, 1'b1, 32'd501));
  endtask

  task automatic test_time_wrap_max_thresholds();
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(mk_item(bdee_pkg::REQ_ATTACH, 0, 1'b1, 32'hFFFF_0000));
    send_item(mk_item(bdee_pkg::REQ_SAMPLE, 0, 1'b0, 32'hFFFF_8000));
    send_item(mk_item(bdee_pkg::REQ_SAMPLE, 0, 1'b0, 32'h0000_7FFF));
  endtask

  task automatic run_random_phase(input int target, input int unsigned scale);
    bdee_pkg::in_item_t it;
    int          counted;
    int unsigned pick;
    int unsigned slot;
    logic        lvl;
    counted = 0;
    stamp   = $urandom();
    while (counted < target) begin
      pick = $urandom_range(0, 99);
      slot = $urandom_range(0, bdee_pkg::NUM_BUTTONS - 1);
      lvl  = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 49) == 0) stamp = $urandom();
      else stamp = stamp + $urandom_range(0, scale);
      if (pick < 3) begin
        it = mk_item(bdee_pkg::REQ_REMOVE, slot, lvl, stamp);
      end else if (pick < 6) begin
        it = mk_item(REQ_UNUSED, slot, lvl, stamp);
      end else if (pick < 10 || (!attached[slot] && $urandom_range(0, 3) != 0)) begin
        it = mk_item(bdee_pkg::REQ_ATTACH, slot, lvl, stamp);
      end else begin
        lvl = pin_seen[slot] ^ pol_low_mask[slot];
        if ($urandom_range(0, 3) == 0) lvl = ~lvl;
        it = mk_item(bdee_pkg::REQ_SAMPLE, slot, lvl, stamp);
      end
      if (!(it.req_type == REQ_UNUSED ||
            (it.req_type == bdee_pkg::REQ_SAMPLE && !attached[slot])))
        counted++;
      send_item(it);
    end
  endtask

  task automatic test_random_defaults();
    apply_settings(bdee_pkg::DEBOUNCE_MS_RST, bdee_pkg::LONG_PRESS_MS_RST,
                   bdee_pkg::ACTIVE_LOW_RST, bdee_pkg::EVENT_ENABLE_RST);
    run_random_phase(150, 300);
  endtask

  task automatic test_random_zero_thresholds();
    apply_settings(16'd0, 16'd0, 16'($urandom()), 16'($urandom()));
    run_random_phase(80, 3);
  endtask

  task automatic test_random_max_thresholds();
    apply_settings(16'hFFFF, 16'hFFFF, 16'($urandom()), 16'hFFFF);
    run_random_phase(80, 40000);
  endtask

  task automatic test_random_mixed();
    logic [15:0] deb;
    logic [15:0] lp;
    for (int round = 0; round < 3; round++) begin
      deb = 16'($urandom_range(0, 200));
      lp  = 16'($urandom_range(0, 3000));
      apply_settings(deb, lp, 16'($urandom()), 16'($urandom()));
      no_idle = (round == 2);
      run_random_phase(80, ((deb > lp) ? deb : lp) / 3 + 4);
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        $error("unexpected event: slot %0d code %0d last %0b",
               out_item.event_slot, out_item.event_code, out_item.last_in_run);
        mismatches++;
      end else begin
        want_ev = pending_events.pop_front();
        if (out_item.event_slot !== want_ev.event_slot) begin
          $error("event_slot: expected %0d, actual %0d", want_ev.event_slot,
                 out_item.event_slot);
          mismatches++;
        end
        if (out_item.event_code !== want_ev.event_code) begin
          $error("event_code: expected %0d, actual %0d", want_ev.event_code,
                 out_item.event_code);
          mismatches++;
        end
        if (out_item.last_in_run !== want_ev.last_in_run) begin
          $error("last_in_run: expected %0b, actual %0b", want_ev.last_in_run,
                 out_item.last_in_run);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    for (int s = 0; s < bdee_pkg::NUM_BUTTONS; s++) begin
      attached[s]   = 1'b0;
      pin_seen[s]   = 1'b0;
      level_ok[s]   = 1'b0;
      long_seen[s]  = 1'b0;
      edge_stamp[s] = '0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_press_release_click();
    test_long_press();
    test_ignored_requests();
    test_zero_thresholds_polarity_enable();
    test_time_wrap_max_thresholds();
    test_random_defaults();
    test_random_zero_thresholds();
    test_random_max_thresholds();
    test_random_mixed();

    drain_pipeline();
    repeat (20) @(posedge clk);
    if (pending_events.size() != 0) begin
      $error("%0d expected events never arrived", pending_events.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bdee_pkg.sv
rtl/button_debounce_event_engine.sv
sim/button_debounce_event_engine_tb.sv
